// File: rtl/lbst_pkg.sv
// shared constants and types of the largest-box smoothed tracker
`default_nettype none

package lbst_pkg;

  // fixed point: 1.0 = 2^FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 17;                 // coordinate and register width
  localparam int AREA_W    = 2 * VAL_W - 1;      // saturated area width
  localparam int ERR_W     = VAL_W + 4;          // signed doubled error
  localparam int MAG_W     = ERR_W - 1;          // magnitude of doubled error
  localparam int PROD_W    = MAG_W + VAL_W;      // shared multiplier product
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0]  ONE_FX   = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0]  HALF_FX  = VAL_W'(1) << (FRAC_BITS - 1);
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // register reset values
  localparam logic [VAL_W-1:0] GAIN_RST     = VAL_W'(6554);
  localparam logic [VAL_W-1:0] DEAD_BAND_RST = VAL_W'(3277);
  localparam logic [VAL_W-1:0] MAX_STEP_RST = VAL_W'(6554);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEAD_BAND = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_STEP  = CFG_IDX_W'(2);

  // step limits handed to the axis update
  typedef struct packed {
    logic [VAL_W-1:0] dead_band;
    logic [VAL_W-1:0] max_step;
  } lbst_limits_t;

endpackage

`default_nettype wire

// File: rtl/largest_box_smoothed_tracker.sv
// top level of the largest-box smoothed tracker: sequencer, state and ports
`default_nettype none

// Boxes of one frame come in one beat each, last_box set on the final one. The
// block keeps the box with the strictly largest area (first wins on ties, zero
// area never kept). On the last box it emits one result beat: found, and the
// smoothed center (y flipped) moved toward the kept box by gain * error, with
// steps under dead_band zeroed, steps limited to max_step and the position
// clamped to 0..1 (1.0 = 65536). A frame with no box of positive area reports
// found = 0 and the unchanged position. One 20 x 17 bit registered multiplier
// does all products in turn: the area of each box, then on the last box of a
// frame with a kept box the x and y steps, each in its error and post state;
// a last box also waits while the previous result beat stays stalled.
// in_stall is low only while the sequencer is idle; a finished result sits in
// the output register, so the next box is taken while it waits. Configuration
// writes are always ready and must only happen while the block is idle.
module largest_box_smoothed_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // box channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lbst_pkg::VAL_W-1:0]    in_box_left,
  input  wire logic [lbst_pkg::VAL_W-1:0]    in_box_top,
  input  wire logic [lbst_pkg::VAL_W-1:0]    in_box_width,
  input  wire logic [lbst_pkg::VAL_W-1:0]    in_box_height,
  input  wire logic                          in_last_box,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic      [lbst_pkg::VAL_W-1:0]    out_pos_x,
  output logic      [lbst_pkg::VAL_W-1:0]    out_pos_y,
  // register writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lbst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbst_pkg::VAL_W-1:0]    cfg_data
);

  localparam int VW = lbst_pkg::VAL_W;
  localparam int EW = lbst_pkg::ERR_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AREA  = 7'b0000010,
    S_ERRX  = 7'b0000100,
    S_POSTX = 7'b0001000,
    S_ERRY  = 7'b0010000,
    S_POSTY = 7'b0100000,
    S_OUT   = 7'b1000000
  } lbst_state_t;

  lbst_state_t state_r, state_nxt;

  // configuration
  logic [VW-1:0] gain_r, dead_band_r, max_step_r;

  // latched box of the current beat
  logic [VW-1:0] box_left_r, box_top_r, box_width_r, box_height_r;
  logic          last_r;

  // frame state
  logic [lbst_pkg::AREA_W-1:0] best_area_r;
  logic [VW-1:0] best_left_r, best_top_r, best_width_r, best_height_r;
  logic [VW-1:0] prev_x_r, prev_y_r;
  logic          found_r;
  logic          neg_r;

  // result register
  logic          out_valid_r, out_found_r;
  logic [VW-1:0] out_pos_x_r, out_pos_y_r;

  logic in_accept, out_load;

  // shared multiplier
  logic                         mul_load;
  logic [lbst_pkg::MAG_W-1:0]   mul_a;
  logic [VW-1:0]                mul_b;
  logic [lbst_pkg::PROD_W-1:0]  prod;

  // area compare
  logic [lbst_pkg::AREA_W-1:0]  area_sat;
  logic                         area_win;

  // error of the axis being worked on
  logic signed [EW-1:0] tgt2, err2;
  logic [lbst_pkg::MAG_W-1:0] err_abs;
  logic [VW-1:0] prev_sel, next_pos;
  lbst_pkg::lbst_limits_t limits;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  // a result goes out once the register is empty or being drained
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // area saturates at the width of best_area
  assign area_sat = (prod[lbst_pkg::PROD_W-1:lbst_pkg::AREA_W] != '0)
                    ? lbst_pkg::AREA_MAX : prod[lbst_pkg::AREA_W-1:0];
  assign area_win = area_sat > best_area_r;

  // doubled target and error; y is flipped
  always_comb begin
    if (state_r == S_ERRY) begin
      tgt2     = $signed(EW'({lbst_pkg::ONE_FX, 1'b0}))
                 - $signed(EW'({best_top_r, 1'b0}))
                 - $signed(EW'(best_height_r));
      prev_sel = prev_y_r;
    end else begin
      tgt2     = $signed(EW'({best_left_r, 1'b0})) + $signed(EW'(best_width_r));
      prev_sel = prev_x_r;
    end
    if (state_r == S_POSTY) begin
      prev_sel = prev_y_r;
    end
    err2    = tgt2 - $signed(EW'({prev_sel, 1'b0}));
    err_abs = err2[EW-1] ? lbst_pkg::MAG_W'(-err2) : lbst_pkg::MAG_W'(err2);
  end

  // multiplier operands: width x height on accept, |error| x gain per axis
  always_comb begin
    mul_load = in_accept || (state_r == S_ERRX) || (state_r == S_ERRY);
    if (state_r == S_IDLE) begin
      mul_a = lbst_pkg::MAG_W'(in_box_width);
      mul_b = in_box_height;
    end else begin
      mul_a = err_abs;
      mul_b = gain_r;
    end
  end

  lbst_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign limits.dead_band = dead_band_r;
  assign limits.max_step  = max_step_r;

  lbst_axis_step u_axis (
    .prod   (prod),
    .neg    (neg_r),
    .prev   (prev_sel),
    .limits (limits),
    .next   (next_pos)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_AREA;
        end
      end
      S_AREA: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (area_win || (best_area_r != '0)) begin
          state_nxt = S_ERRX;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ERRX:  state_nxt = S_POSTX;
      S_POSTX: state_nxt = S_ERRY;
      S_ERRY:  state_nxt = S_POSTY;
      S_POSTY: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= lbst_pkg::GAIN_RST;
      dead_band_r <= lbst_pkg::DEAD_BAND_RST;
      max_step_r  <= lbst_pkg::MAX_STEP_RST;
      best_area_r <= '0;
      best_left_r <= '0;
      best_top_r  <= '0;
      best_width_r  <= '0;
      best_height_r <= '0;
      prev_x_r    <= lbst_pkg::HALF_FX;
      prev_y_r    <= lbst_pkg::HALF_FX;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lbst_pkg::CFG_IDX_GAIN:      gain_r      <= cfg_data;
          lbst_pkg::CFG_IDX_DEAD_BAND: dead_band_r <= cfg_data;
          lbst_pkg::CFG_IDX_MAX_STEP:  max_step_r  <= cfg_data;
          default: ;
        endcase
      end

      // strictly larger area replaces the kept box
      if ((state_r == S_AREA) && area_win) begin
        best_area_r   <= area_sat;
        best_left_r   <= box_left_r;
        best_top_r    <= box_top_r;
        best_width_r  <= box_width_r;
        best_height_r <= box_height_r;
      end
      if (state_r == S_AREA) begin
        found_r <= area_win || (best_area_r != '0);
      end

      if (state_r == S_POSTX) begin
        prev_x_r <= next_pos;
      end
      if (state_r == S_POSTY) begin
        prev_y_r <= next_pos;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        best_area_r <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      box_left_r   <= in_box_left;
      box_top_r    <= in_box_top;
      box_width_r  <= in_box_width;
      box_height_r <= in_box_height;
      last_r       <= in_last_box;
    end
    if ((state_r == S_ERRX) || (state_r == S_ERRY)) begin
      neg_r <= err2[EW-1];
    end
    if (out_load) begin
      out_found_r <= found_r;
      out_pos_x_r <= prev_x_r;
      out_pos_y_r <= prev_y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;

  // stored position never leaves 0..1
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (prev_x_r <= lbst_pkg::ONE_FX) && (prev_y_r <= lbst_pkg::ONE_FX))
    else $error("stored position out of range");

  // a result beat only comes from the output state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside output state");

  // kept area is cleared once a frame's result is loaded
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (best_area_r == '0))
    else $error("best area not cleared after frame");

  // a frame without a positive-area box leaves the position alone
  a_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_AREA) && last_r && !area_win && (best_area_r == '0))
      |=> $stable(prev_x_r) && $stable(prev_y_r))
    else $error("position moved without a box");

endmodule

`default_nettype wire

// File: rtl/lbst_mul.sv
// shared registered multiplier used for the area and both axis steps
`default_nettype none

module lbst_mul (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [lbst_pkg::MAG_W-1:0]  op_a,
  input  wire logic [lbst_pkg::VAL_W-1:0]  op_b,
  output logic      [lbst_pkg::PROD_W-1:0] prod
);

  logic [lbst_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= lbst_pkg::PROD_W'(op_a) * lbst_pkg::PROD_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: rtl/lbst_axis_step.sv
// rounding, dead band, step limit and clamp of one axis update
`default_nettype none

module lbst_axis_step (
  input  wire logic [lbst_pkg::PROD_W-1:0] prod,
  input  wire logic                        neg,
  input  wire logic [lbst_pkg::VAL_W-1:0]  prev,
  input  wire lbst_pkg::lbst_limits_t      limits,
  output logic      [lbst_pkg::VAL_W-1:0]  next
);

  localparam int RND_W = lbst_pkg::PROD_W + 1;
  localparam int RAW_W = RND_W - (lbst_pkg::FRAC_BITS + 1);
  localparam int SUM_W = lbst_pkg::VAL_W + 2;

  logic [RND_W-1:0]          rnd;
  logic [RAW_W-1:0]          mag_raw;
  logic [lbst_pkg::VAL_W-1:0] mag_lim;
  logic signed [SUM_W-1:0]   sum;

  always_comb begin
    // round half up, drop the extra fraction bit of the doubled error
    rnd     = {1'b0, prod} + RND_W'(lbst_pkg::ONE_FX);
    mag_raw = rnd[RND_W-1 -: RAW_W];

    if (mag_raw < RAW_W'(limits.dead_band)) begin
      mag_lim = '0;
    end else if (mag_raw > RAW_W'(limits.max_step)) begin
      mag_lim = limits.max_step;
    end else begin
      mag_lim = mag_raw[lbst_pkg::VAL_W-1:0];
    end

    if (neg) begin
      sum = $signed({2'b00, prev}) - $signed({2'b00, mag_lim});
    end else begin
      sum = $signed({2'b00, prev}) + $signed({2'b00, mag_lim});
    end

    if (sum < 0) begin
      next = '0;
    end else if (sum > $signed(SUM_W'(lbst_pkg::ONE_FX))) begin
      next = lbst_pkg::ONE_FX;
    end else begin
      next = sum[lbst_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: dv/largest_box_smoothed_tracker_tb.sv
// self-checking testbench of the largest-box smoothed tracker
`timescale 1ns / 1ps

module largest_box_smoothed_tracker_tb;

  localparam int VW = lbst_pkg::VAL_W;
  localparam int IW = lbst_pkg::CFG_IDX_W;

  // index 3 is not a register: a write there must change nothing
  localparam logic [IW-1:0] CFG_IDX_SPARE = IW'(3);
  localparam int IDLE_PCT     = 37;
  localparam int SETTLE_CYCLES = 16;   // covers the position update plus margin
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_BOXES  = 135;

  typedef struct packed {
    logic [VW-1:0] left;
    logic [VW-1:0] top;
    logic [VW-1:0] width;
    logic [VW-1:0] height;
    logic          last;
  } box_t;

  typedef struct packed {
    logic          found;
    logic [VW-1:0] pos_x;
    logic [VW-1:0] pos_y;
  } position_t;

  // predicts the smoothed position of every frame and checks the result beats
  class track_scoreboard;
    logic [VW-1:0]   gain, dead_band, max_step;
    longint unsigned best_area;
    longint          best_left, best_top, best_width, best_height;
    longint          cur_x, cur_y;
    position_t       pending_positions[$];
    int              errors, checked, frames, frames_found;

    function new();
      gain      = lbst_pkg::GAIN_RST;
      dead_band = lbst_pkg::DEAD_BAND_RST;
      max_step  = lbst_pkg::MAX_STEP_RST;
      best_area = 0;
      best_left = 0;
      best_top  = 0;
      best_width  = 0;
      best_height = 0;
      cur_x = longint'(lbst_pkg::HALF_FX);
      cur_y = longint'(lbst_pkg::HALF_FX);
      errors = 0;
      checked = 0;
      frames = 0;
      frames_found = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [VW-1:0] val);
      case (idx)
        lbst_pkg::CFG_IDX_GAIN:      gain = val;
        lbst_pkg::CFG_IDX_DEAD_BAND: dead_band = val;
        lbst_pkg::CFG_IDX_MAX_STEP:  max_step = val;
        default: ;
      endcase
    endfunction

    // one axis: rounded gain step, dead band, step limit, clamp to 0..1
    function longint smooth_axis(longint prev, longint target2);
      longint          err2, nxt;
      longint unsigned mag;
      bit              neg;
      err2 = target2 - 2 * prev;
      neg  = err2 < 0;
      mag  = neg ? -err2 : err2;
      mag  = (mag * 64'(gain) + 64'(lbst_pkg::ONE_FX)) >> (lbst_pkg::FRAC_BITS + 1);
      if (mag < 64'(dead_band)) mag = 0;
      if (mag > 64'(max_step)) mag = 64'(max_step);
      nxt = neg ? prev - longint'(mag) : prev + longint'(mag);
      if (nxt < 0) nxt = 0;
      if (nxt > longint'(lbst_pkg::ONE_FX)) nxt = longint'(lbst_pkg::ONE_FX);
      return nxt;
    endfunction

    function void note_box(box_t b);
      longint unsigned area;
      longint          w, h, tx2, ty2;
      position_t       p;
      w = longint'(b.width);
      h = longint'(b.height);
      area = w * h;
      if (area > 64'(lbst_pkg::AREA_MAX)) area = 64'(lbst_pkg::AREA_MAX);
      if (area > best_area) begin
        best_area   = area;
        best_left   = longint'(b.left);
        best_top    = longint'(b.top);
        best_width  = w;
        best_height = h;
      end
      if (!b.last) return;
      frames++;
      p.found = best_area > 0;
      if (p.found) begin
        frames_found++;
        tx2 = 2 * best_left + best_width;
        ty2 = 2 * longint'(lbst_pkg::ONE_FX) - 2 * best_top - best_height;
        cur_x = smooth_axis(cur_x, tx2);
        cur_y = smooth_axis(cur_y, ty2);
      end
      best_area = 0;
      p.pos_x = cur_x[VW-1:0];
      p.pos_y = cur_y[VW-1:0];
      pending_positions.push_back(p);
    endfunction

    function int pending();
      return pending_positions.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      if (errors < 100)
        $display("mismatch at result %0d: %s got %0d expected %0d", checked, what, got, want);
      errors++;
    endtask

    task check_result(logic found, logic [VW-1:0] x, logic [VW-1:0] y);
      position_t want;
      if (pending_positions.size() == 0) begin
        report_mismatch("result beat with none pending", 64'sd1, 64'sd0);
        return;
      end
      want = pending_positions.pop_front();
      checked++;
      if (found !== want.found)
        report_mismatch("found", longint'(found), longint'(want.found));
      if (x !== want.pos_x)
        report_mismatch("pos_x", longint'(x), longint'(want.pos_x));
      if (y !== want.pos_y)
        report_mismatch("pos_y", longint'(y), longint'(want.pos_y));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VW-1:0] in_box_left = '0;
  logic [VW-1:0] in_box_top = '0;
  logic [VW-1:0] in_box_width = '0;
  logic [VW-1:0] in_box_height = '0;
  logic          in_last_box = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_found;
  logic [VW-1:0] out_pos_x;
  logic [VW-1:0] out_pos_y;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [VW-1:0] cfg_data = '0;

  track_scoreboard sb = new();

  // idling switches for both sides, turned off for one long stretch
  bit in_gaps  = 1'b1;
  bit out_gaps = 1'b1;
  int boxes_sent = 0;
  int reg_writes = 0;
  int settings   = 0;

  largest_box_smoothed_tracker dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_box_left   (in_box_left),
    .in_box_top    (in_box_top),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_last_box   (in_last_box),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk)
    out_stall <= out_gaps && ($urandom_range(99) < IDLE_PCT);

  // a result beat moves on a rising edge with valid high and stall low
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_found, out_pos_x, out_pos_y);

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // entered and left at a falling edge; valid stays high between back-to-back beats
  task automatic send_box(box_t b);
    while (in_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_box_left   <= b.left;
    in_box_top    <= b.top;
    in_box_width  <= b.width;
    in_box_height <= b.height;
    in_last_box   <= b.last;
    do @(posedge clk); while (in_stall);
    sb.note_box(b);
    boxes_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait for every pending result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // cfg_valid is only lowered once the whole group of writes is done
  task automatic write_reg(logic [IW-1:0] idx, logic [VW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic configure(logic [VW-1:0] g, logic [VW-1:0] d, logic [VW-1:0] m);
    drain();
    write_reg(lbst_pkg::CFG_IDX_GAIN, g);
    write_reg(lbst_pkg::CFG_IDX_DEAD_BAND, d);
    write_reg(lbst_pkg::CFG_IDX_MAX_STEP, m);
    if (settings == 3) write_reg(CFG_IDX_SPARE, VW'($urandom_range(0, 2 ** VW - 1)));
    cfg_valid <= 1'b0;
    settings++;
    @(negedge clk);
  endtask

  function automatic logic [VW-1:0] edge_value();
    case ($urandom_range(5))
      0: return '0;
      1: return VW'(1);
      2: return lbst_pkg::HALF_FX;
      3: return lbst_pkg::ONE_FX - VW'(1);
      4: return lbst_pkg::ONE_FX;
      default: return '1;
    endcase
  endfunction

  function automatic logic [VW-1:0] random_reg_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return edge_value();
    if (pick < 45) return VW'($urandom_range(0, 2 ** VW - 1));   // above 1.0 too
    if (pick < 75) return VW'($urandom_range(0, 8192));
    return VW'($urandom_range(0, 65536));
  endfunction

  // mostly boxes that sit inside the frame, plus raw fields, empties and ties
  function automatic box_t random_box(box_t prev);
    box_t b;
    int   kind;
    kind = $urandom_range(99);
    b.last = 1'b0;
    if (kind < 60) begin
      b.width  = $urandom_range(1) ? VW'($urandom_range(1, 8192))
                                   : VW'($urandom_range(1, 65536));
      b.height = $urandom_range(1) ? VW'($urandom_range(1, 8192))
                                   : VW'($urandom_range(1, 65536));
      b.left   = VW'($urandom_range(0, 65536 - int'(b.width)));
      b.top    = VW'($urandom_range(0, 65536 - int'(b.height)));
    end else if (kind < 75) begin
      b.left   = VW'($urandom_range(0, 2 ** VW - 1));
      b.top    = VW'($urandom_range(0, 2 ** VW - 1));
      b.width  = VW'($urandom_range(0, 2 ** VW - 1));
      b.height = VW'($urandom_range(0, 2 ** VW - 1));
    end else if (kind < 85) begin
      // zero area, never kept
      b.left   = VW'($urandom_range(0, 65536));
      b.top    = VW'($urandom_range(0, 65536));
      b.width  = $urandom_range(1) ? '0 : VW'($urandom_range(0, 65536));
      b.height = (b.width == 0) ? VW'($urandom_range(0, 65536)) : '0;
    end else if (kind < 95) begin
      // same area as the previous box at another place, earlier one must win
      b.width  = prev.height;
      b.height = prev.width;
      b.left   = VW'($urandom_range(0, 65536));
      b.top    = VW'($urandom_range(0, 65536));
    end else begin
      b.left   = edge_value();
      b.top    = edge_value();
      b.width  = edge_value();
      b.height = edge_value();
    end
    return b;
  endfunction

  task automatic run_random(int n, bit with_pause);
    box_t b, prev;
    int   sent, len;
    sent = 0;
    prev = '0;
    while (sent < n) begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        b = random_box(prev);
        b.last = (k == len - 1);
        // broken framing now and then: early or missing last flag
        if ($urandom_range(99) < 8) b.last = 1'($urandom_range(1));
        send_box(b);
        prev = b;
        sent++;
      end
      // hold the sender until every result is back, once mid-phase
      if (with_pause && sent >= n / 2) begin
        with_pause = 1'b0;
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    box_t directed[$];
    logic [VW-1:0] g, d, m;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames under the reset settings
    directed = '{
      // zero width, then zero height: nothing found
      '{VW'(100), VW'(200), '0, VW'(500), 1'b1},
      '{VW'(100), VW'(200), VW'(500), '0, 1'b1},
      // full frame centered: no error, no move
      '{'0, '0, lbst_pkg::ONE_FX, lbst_pkg::ONE_FX, 1'b1},
      // tiny box in the top-left corner
      '{'0, '0, VW'(1), VW'(1), 1'b1},
      // equal areas: the first stays, the last box has zero area
      '{'0, '0, VW'(100), VW'(200), 1'b0},
      '{VW'(60000), VW'(60000), VW'(200), VW'(100), 1'b0},
      '{VW'(30000), VW'(30000), VW'(10), VW'(10), 1'b0},
      '{VW'(40000), VW'(40000), '0, '0, 1'b1},
      // a later larger box takes over
      '{'0, '0, VW'(10), VW'(10), 1'b0},
      '{VW'(50000), VW'(1000), VW'(1000), VW'(1000), 1'b1},
      // saturated areas tie, first wins, x target just below one, y just above zero
      '{'0, '0, '1, '1, 1'b0},
      '{'1, '1, '1, '1, 1'b1},
      // all-ones box alone: x far above one, y far below zero
      '{'1, '1, '1, '1, 1'b1},
      '{lbst_pkg::ONE_FX, lbst_pkg::ONE_FX, VW'(1), VW'(1), 1'b1},
      '{lbst_pkg::ONE_FX - VW'(1), '0, VW'(1), lbst_pkg::ONE_FX, 1'b1},
      '{lbst_pkg::HALF_FX, lbst_pkg::HALF_FX, lbst_pkg::HALF_FX, lbst_pkg::HALF_FX, 1'b1}
    };
    foreach (directed[i]) send_box(directed[i]);

    // extreme settings first, then random ones
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin g = lbst_pkg::ONE_FX;   d = '0;                m = lbst_pkg::ONE_FX; end
        1: begin g = '0;                 d = '0;                m = '1;               end
        2: begin g = '1;                 d = '0;                m = '1;               end
        3: begin g = lbst_pkg::GAIN_RST; d = '1;                m = '1;               end
        4: begin g = lbst_pkg::HALF_FX;  d = VW'(1);            m = '0;               end
        5: begin g = lbst_pkg::ONE_FX;   d = lbst_pkg::ONE_FX;  m = VW'(1);           end
        default: begin
          g = random_reg_value();
          d = random_reg_value();
          m = random_reg_value();
        end
      endcase
      configure(g, d, m);
      // one phase runs with no idling on either side
      in_gaps  = (p != 6);
      out_gaps = (p != 6);
      run_random(PHASE_BOXES, 1'b1);
    end

    drain();
    $display("covered %0d boxes in %0d frames (%0d with a kept box), %0d results checked",
             boxes_sent, sb.frames, sb.frames_found, sb.checked);
    $display("%0d register writes over %0d settings, extremes and gain above one included",
             reg_writes, settings);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
